>>> rtl/core/disk_head_scheduler_defines.svh
// Assertion macros shared by the disk head scheduler RTL.
`ifndef DISK_HEAD_SCHEDULER_DEFINES_SVH
`define DISK_HEAD_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define DHS_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define DHS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/dhs_pkg.sv
// Shared types, codes and helpers of the disk head scheduler.
package dhs_pkg;

  localparam int TrackW = 16;
  localparam int TotalW = 24;
  localparam int AlgW   = 2;
  localparam int CfgIdxW = 2;

  localparam logic [TrackW-1:0] MaxTrackReset = 16'd199;
  localparam logic [TotalW-1:0] TotalMax      = {TotalW{1'b1}};

  // Algorithm codes; the unused code falls back to first come first serve
  localparam logic [AlgW-1:0] ALG_FCFS  = 2'd0;
  localparam logic [AlgW-1:0] ALG_SCAN  = 2'd1;
  localparam logic [AlgW-1:0] ALG_CSCAN = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ALGORITHM = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SCAN_DIR  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_START     = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_TRACK = 2'd3;

  // Kind of result loaded into the output register
  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_RAM,
    EMIT_TOP,
    EMIT_ZERO,
    EMIT_JUMP
  } emit_kind_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       ins;       // store the incoming request
    logic       copy;      // shift the sorted row out into the sorted RAM
    logic       run_init;  // park head at start, clear total
    logic       clr;       // batch finished, empty the store
    emit_kind_t emit;
    logic       src_fcfs;  // take visited track from the arrival RAM
    logic       last;      // result closes the batch
  } dhs_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic            out_free;
    logic [AlgW-1:0] alg;
    logic            dir;
  } dhs_stat_t;

  function automatic logic [TrackW-1:0] clamp_track(input logic [TrackW-1:0] t,
                                                    input logic [TrackW-1:0] m);
    clamp_track = (t > m) ? m : t;
  endfunction

endpackage

>>> rtl/core/dhs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dhs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/dhs_datapath.sv
// Datapath: configuration, sorting row, request RAMs, head tracking, output register.
module dhs_datapath #(
  parameter int MAX_REQUESTS = 32,
  localparam int CntW = $clog2(MAX_REQUESTS + 1),
  localparam int IdxW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration writes
  input  logic                          cfg_valid,
  input  logic [dhs_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [dhs_pkg::TrackW-1:0]    cfg_data,
  // request payload
  input  logic [dhs_pkg::TrackW-1:0]    track,
  // controller link
  input  dhs_pkg::dhs_cmd_t             cmd,
  input  logic [IdxW-1:0]               addr,
  output dhs_pkg::dhs_stat_t            stat,
  output logic [CntW-1:0]               req_count,
  output logic [CntW-1:0]               below_count,
  output logic [CntW-1:0]               upto_count,
  // result register
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [dhs_pkg::TrackW-1:0]    visit_track,
  output logic [dhs_pkg::TrackW-1:0]    step_distance,
  output logic [dhs_pkg::TotalW-1:0]    total_distance,
  output logic                          is_edge,
  output logic                          end_of_run
);

  import dhs_pkg::*;

  // configuration registers
  logic [AlgW-1:0]   algorithm;
  logic              scan_direction;
  logic [TrackW-1:0] start_head;
  logic [TrackW-1:0] max_track;

  // run state
  logic [TrackW-1:0] head;
  logic [TotalW-1:0] total;

  // sorted row
  logic [TrackW-1:0] row     [MAX_REQUESTS];
  logic [TrackW-1:0] ins_row [MAX_REQUESTS];
  logic [TrackW-1:0] sh_row  [MAX_REQUESTS];
  logic              gt      [MAX_REQUESTS];

  logic [TrackW-1:0] trk_c;
  logic [TrackW-1:0] start_c;
  logic [TrackW-1:0] copy_val;
  logic              store_en;
  logic [TrackW-1:0] arr_rdata;
  logic [TrackW-1:0] srt_rdata;

  logic [TrackW-1:0] e_trk;
  logic              e_edge;
  logic [TrackW-1:0] e_dist;
  logic [TotalW:0]   e_sum;
  logic [TotalW-1:0] e_total;

  assign trk_c    = clamp_track(track, max_track);
  assign start_c  = clamp_track(start_head, max_track);
  assign copy_val = clamp_track(row[0], max_track);
  assign store_en = cmd.ins && (req_count < CntW'(MAX_REQUESTS));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      algorithm      <= ALG_FCFS;
      scan_direction <= 1'b1;
      start_head     <= '0;
      max_track      <= MaxTrackReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ALGORITHM: algorithm      <= cfg_data[AlgW-1:0];
        CFG_SCAN_DIR:  scan_direction <= cfg_data[0];
        CFG_START:     start_head     <= cfg_data;
        CFG_MAX_TRACK: max_track      <= cfg_data;
      endcase
    end
  end

  // Insertion: cells past the fill count act as larger than any track
  always_comb begin
    for (int i = 0; i < MAX_REQUESTS; i++) begin
      gt[i] = (CntW'(i) >= req_count) || (row[i] > trk_c);
    end
    ins_row[0] = gt[0] ? trk_c : row[0];
    for (int i = 1; i < MAX_REQUESTS; i++) begin
      ins_row[i] = gt[i] ? (gt[i-1] ? row[i-1] : trk_c) : row[i];
    end
  end

  // Shift toward cell zero while copying out
  always_comb begin
    sh_row[MAX_REQUESTS-1] = row[MAX_REQUESTS-1];
    for (int i = 0; i < MAX_REQUESTS - 1; i++) begin
      sh_row[i] = row[i+1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_REQUESTS; i++) begin
      if (store_en) begin
        row[i] <= ins_row[i];
      end else if (cmd.copy) begin
        row[i] <= sh_row[i];
      end
    end
  end

  // Fill count and partition counts relative to the start track
  always_ff @(posedge clk) begin
    if (rst) begin
      req_count <= '0;
    end else if (cmd.clr) begin
      req_count <= '0;
    end else if (store_en) begin
      req_count <= req_count + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      below_count <= '0;
      upto_count  <= '0;
    end else if (cmd.copy) begin
      below_count <= below_count + CntW'(copy_val < start_c);
      upto_count  <= upto_count + CntW'(copy_val <= start_c);
    end
  end

  // Requests in arrival order
  dhs_ram #(.WIDTH(TrackW), .DEPTH(MAX_REQUESTS)) u_arr_ram (
    .clk   (clk),
    .we    (store_en),
    .waddr (req_count[IdxW-1:0]),
    .wdata (trk_c),
    .raddr (addr),
    .rdata (arr_rdata)
  );

  // Requests in ascending order
  dhs_ram #(.WIDTH(TrackW), .DEPTH(MAX_REQUESTS)) u_srt_ram (
    .clk   (clk),
    .we    (cmd.copy),
    .waddr (addr),
    .wdata (copy_val),
    .raddr (addr),
    .rdata (srt_rdata)
  );

  // Pick the stop, its distance and the saturated running total
  always_comb begin
    unique case (cmd.emit)
      EMIT_RAM: begin
        e_trk  = cmd.src_fcfs ? clamp_track(arr_rdata, max_track) : srt_rdata;
        e_edge = 1'b0;
      end
      EMIT_TOP: begin
        e_trk  = max_track;
        e_edge = 1'b1;
      end
      EMIT_ZERO, EMIT_JUMP: begin
        e_trk  = '0;
        e_edge = 1'b1;
      end
      default: begin
        e_trk  = '0;
        e_edge = 1'b0;
      end
    endcase
    if (cmd.emit == EMIT_JUMP) begin
      e_dist = max_track;
    end else begin
      e_dist = (e_trk > head) ? (e_trk - head) : (head - e_trk);
    end
    e_sum   = {1'b0, total} + (TotalW + 1)'(e_dist);
    e_total = e_sum[TotalW] ? TotalMax : e_sum[TotalW-1:0];
  end

  // Head position and total
  always_ff @(posedge clk) begin
    if (cmd.run_init) begin
      head  <= start_c;
      total <= '0;
    end else if (cmd.emit != EMIT_NONE) begin
      head  <= e_trk;
      total <= e_total;
    end
  end

  // Output register: load a result, drop it once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != EMIT_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != EMIT_NONE) begin
      visit_track    <= e_trk;
      step_distance  <= e_dist;
      total_distance <= e_total;
      is_edge        <= e_edge;
      end_of_run     <= cmd.last;
    end
  end

  assign stat.out_free = !out_valid || out_ready;
  assign stat.alg      = algorithm;
  assign stat.dir      = scan_direction;

endmodule

>>> rtl/core/dhs_ctrl.sv
// Controller: loads a batch, copies it out sorted (SCAN and C-SCAN), then walks the service order.
module dhs_ctrl #(
  parameter int MAX_REQUESTS = 32,
  localparam int CntW = $clog2(MAX_REQUESTS + 1),
  localparam int IdxW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  input  dhs_pkg::dhs_stat_t stat,
  input  logic [CntW-1:0]    req_count,
  input  logic [CntW-1:0]    below_count,
  input  logic [CntW-1:0]    upto_count,
  output dhs_pkg::dhs_cmd_t  cmd,
  output logic [IdxW-1:0]    addr
);

  import dhs_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD,
    S_COPY,
    S_SETUP,
    S_FETCH,
    S_EMIT,
    S_EDGE,
    S_JUMP
  } state_t;

  state_t          state;
  logic [IdxW-1:0] idx;
  logic [CntW-1:0] rem;
  logic            down;
  logic            seg2;

  logic            is_scan;
  logic            is_cscan;
  logic            is_fcfs;
  logic            up_first;
  logic [CntW-1:0] above_count;
  logic [CntW-1:0] past_count;
  logic [CntW-1:0] rem1;
  logic [CntW-1:0] rem2;
  logic            copy_done;

  assign is_scan     = (stat.alg == ALG_SCAN);
  assign is_cscan    = (stat.alg == ALG_CSCAN);
  assign is_fcfs     = !is_scan && !is_cscan;
  assign up_first    = is_cscan || stat.dir;
  assign above_count = req_count - below_count;
  assign past_count  = req_count - upto_count;
  assign copy_done   = ((CntW'(idx) + CntW'(1)) == req_count);

  // Lengths of the first and the return sweep
  always_comb begin
    if (is_fcfs) begin
      rem1 = req_count;
    end else if (up_first) begin
      rem1 = above_count;
    end else begin
      rem1 = upto_count;
    end
    rem2 = stat.dir ? below_count : past_count;
  end

  assign in_ready = (state == S_LOAD);
  assign addr     = idx;

  // Commands for the current state
  always_comb begin
    cmd          = '0;
    cmd.emit     = EMIT_NONE;
    cmd.src_fcfs = is_fcfs;
    unique case (state)
      S_LOAD: begin
        cmd.ins = in_valid;
      end
      S_COPY: begin
        cmd.copy = 1'b1;
      end
      S_SETUP: begin
        cmd.run_init = 1'b1;
      end
      S_FETCH: begin
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = EMIT_RAM;
          cmd.last = (rem == CntW'(1)) && (seg2 || is_fcfs);
        end
      end
      S_EDGE: begin
        if (stat.out_free) begin
          cmd.emit = up_first ? EMIT_TOP : EMIT_ZERO;
          cmd.last = is_scan && (rem2 == '0);
        end
      end
      S_JUMP: begin
        if (stat.out_free) begin
          cmd.emit = EMIT_JUMP;
          cmd.last = (below_count == '0);
        end
      end
    endcase
    cmd.clr = cmd.last && (cmd.emit != EMIT_NONE);
  end

  // State, walk index and sweep counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      idx   <= '0;
      rem   <= '0;
      down  <= 1'b0;
      seg2  <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_valid && in_last) begin
            idx   <= '0;
            state <= is_fcfs ? S_SETUP : S_COPY;
          end
        end
        S_COPY: begin
          if (copy_done) begin
            state <= S_SETUP;
          end else begin
            idx <= idx + IdxW'(1);
          end
        end
        S_SETUP: begin
          seg2 <= 1'b0;
          rem  <= rem1;
          if (is_fcfs) begin
            idx  <= '0;
            down <= 1'b0;
          end else if (up_first) begin
            idx  <= below_count[IdxW-1:0];
            down <= 1'b0;
          end else begin
            idx  <= upto_count[IdxW-1:0] - IdxW'(1);
            down <= 1'b1;
          end
          state <= (rem1 == '0) ? S_EDGE : S_FETCH;
        end
        S_FETCH: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (stat.out_free) begin
            rem <= rem - CntW'(1);
            idx <= down ? (idx - IdxW'(1)) : (idx + IdxW'(1));
            if (rem != CntW'(1)) begin
              state <= S_FETCH;
            end else if (seg2 || is_fcfs) begin
              state <= S_LOAD;
            end else begin
              state <= S_EDGE;
            end
          end
        end
        S_EDGE: begin
          if (stat.out_free) begin
            seg2 <= 1'b1;
            if (is_cscan) begin
              state <= S_JUMP;
            end else begin
              rem <= rem2;
              if (stat.dir) begin
                idx  <= below_count[IdxW-1:0] - IdxW'(1);
                down <= 1'b1;
              end else begin
                idx  <= upto_count[IdxW-1:0];
                down <= 1'b0;
              end
              state <= (rem2 == '0) ? S_LOAD : S_FETCH;
            end
          end
        end
        S_JUMP: begin
          if (stat.out_free) begin
            idx   <= '0;
            rem   <= below_count;
            down  <= 1'b0;
            state <= (below_count == '0) ? S_LOAD : S_FETCH;
          end
        end
      endcase
    end
  end

endmodule

>>> rtl/core/disk_head_scheduler.sv
// Disk head scheduler: requests load one per cycle while loading (fill count up to MAX_REQUESTS).
// After the last request, SCAN and C-SCAN copy the sorted row to RAM, then a setup state runs
// (FCFS goes straight to setup). Each request result passes a registered RAM read, then the
// output register; each edge stop is loaded straight into the output register; both wait
// while the output is stalled.
// Reset (rst, synchronous) returns to loading with an empty batch and default configuration;
// request RAMs are not cleared and need no clearing pass.
`include "disk_head_scheduler_defines.svh"

module disk_head_scheduler #(
  parameter int MAX_REQUESTS = 32,
  localparam int CntW = $clog2(MAX_REQUESTS + 1),
  localparam int IdxW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [dhs_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [dhs_pkg::TrackW-1:0]  cfg_data,
  // request stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [15:0]                 s_tdata,   // [15:0] track
  input  logic                        s_tlast,   // last request of the batch
  // result stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [55:0]                 m_tdata,   // [15:0] visit_track, [31:16] step_distance,
                                                 // [55:32] total_distance
  output logic                        m_tuser,   // [0] is_edge
  output logic                        m_tlast    // end_of_run
);

  import dhs_pkg::*;

  dhs_cmd_t          cmd;
  dhs_stat_t         stat;
  logic [IdxW-1:0]   addr;
  logic [CntW-1:0]   req_count;
  logic [CntW-1:0]   below_count;
  logic [CntW-1:0]   upto_count;
  logic [TrackW-1:0] visit_track;
  logic [TrackW-1:0] step_distance;
  logic [TotalW-1:0] total_distance;

  assign cfg_ready = 1'b1;

  dhs_ctrl #(.MAX_REQUESTS(MAX_REQUESTS)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_last     (s_tlast),
    .in_ready    (s_tready),
    .stat        (stat),
    .req_count   (req_count),
    .below_count (below_count),
    .upto_count  (upto_count),
    .cmd         (cmd),
    .addr        (addr)
  );

  dhs_datapath #(.MAX_REQUESTS(MAX_REQUESTS)) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .track          (s_tdata),
    .cmd            (cmd),
    .addr           (addr),
    .stat           (stat),
    .req_count      (req_count),
    .below_count    (below_count),
    .upto_count     (upto_count),
    .out_ready      (m_tready),
    .out_valid      (m_tvalid),
    .visit_track    (visit_track),
    .step_distance  (step_distance),
    .total_distance (total_distance),
    .is_edge        (m_tuser),
    .end_of_run     (m_tlast)
  );

  assign m_tdata = {total_distance, step_distance, visit_track};

  // Never overwrite a result that has not been transferred
  `DHS_ASSERT_IMPL(a_emit_free, clk, rst, cmd.emit != EMIT_NONE, stat.out_free, "result over busy output")
  // Closing result hands control back to loading
  `DHS_ASSERT_NEXT(a_last_load, clk, rst, (cmd.emit != EMIT_NONE) && cmd.last, s_tready, "no return to load")
  // Fill count stays within the store
  `DHS_ASSERT_IMPL(a_count_cap, clk, rst, 1'b1, req_count <= CntW'(MAX_REQUESTS), "request count overflow")

endmodule

>>> tb/tb.sv
// Self-checking testbench for the disk head scheduler: FCFS, SCAN and C-SCAN service order.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dhs_pkg::*;

  localparam int BatchCap = 32;

  // Selector code with no algorithm of its own
  localparam logic [AlgW-1:0] ALG_SPARE = 2'd3;

  // One stop of the head as the result stream carries it
  typedef struct packed {
    logic [TrackW-1:0] trk;
    logic [TrackW-1:0] step;
    logic [TotalW-1:0] total;
    logic              edge_stop;
    logic              closes;
  } visit_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [TrackW-1:0]   cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [15:0]         s_tdata = '0;   // [15:0] track
  logic                s_tlast = 1'b0; // last request of the batch
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [55:0]         m_tdata;        // [15:0] visit_track, [31:16] step_distance,
                                       // [55:32] total_distance
  logic                m_tuser;        // [0] is_edge
  logic                m_tlast;        // end_of_run

  // Shadow of the block: configuration, loaded batch and head
  logic [AlgW-1:0]     shadow_alg = ALG_FCFS;
  logic                shadow_dir = 1'b1;
  logic [TrackW-1:0]   shadow_start = '0;
  logic [TrackW-1:0]   shadow_top = MaxTrackReset;
  logic [TrackW-1:0]   pending_tracks [0:BatchCap-1];
  int                  pending_cnt = 0;
  logic [TrackW-1:0]   head_pos;
  logic [TotalW-1:0]   moved;
  visit_t              visits_due [$];

  int                  fail_count = 0;
  int                  sent_items = 0;
  bit                  steady = 1'b0;
  int                  sink_hold = 0;

  disk_head_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void note_failure(input string msg);
    if (fail_count < 10) $display("MISMATCH: %s", msg);
    fail_count++;
  endfunction

  function automatic logic [TrackW-1:0] limit_track(input logic [TrackW-1:0] t);
    return (t > shadow_top) ? shadow_top : t;
  endfunction

  // Record one head stop and advance the head and the saturating total
  function automatic void add_stop(input logic [TrackW-1:0] trk, input logic edge_stop,
                                   input logic [TrackW-1:0] span);
    logic [TotalW:0] sum;
    visit_t v;
    sum = {1'b0, moved} + span;
    moved = (sum > {1'b0, TotalMax}) ? TotalMax : sum[TotalW-1:0];
    head_pos = trk;
    v.trk = trk;
    v.step = span;
    v.total = moved;
    v.edge_stop = edge_stop;
    v.closes = 1'b0;
    visits_due.push_back(v);
  endfunction

  function automatic void move_to(input logic [TrackW-1:0] trk, input logic edge_stop);
    add_stop(trk, edge_stop, (trk > head_pos) ? trk - head_pos : head_pos - trk);
  endfunction

  // Work out the service order of the loaded batch and queue its stops
  function automatic void plan_service();
    logic [TrackW-1:0] srt [0:BatchCap-1];
    logic [TrackW-1:0] start;
    logic [TrackW-1:0] v;
    int n;
    int j;
    int first_idx;
    n = pending_cnt;
    start = limit_track(shadow_start);
    head_pos = start;
    moved = '0;
    first_idx = visits_due.size();
    for (int i = 0; i < n; i++) begin
      v = limit_track(pending_tracks[i]);
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    case (shadow_alg)
      ALG_SCAN: begin
        if (shadow_dir) begin
          for (int i = 0; i < n; i++) if (srt[i] >= start) move_to(srt[i], 1'b0);
          move_to(shadow_top, 1'b1);
          for (int i = n - 1; i >= 0; i--) if (srt[i] < start) move_to(srt[i], 1'b0);
        end else begin
          for (int i = n - 1; i >= 0; i--) if (srt[i] <= start) move_to(srt[i], 1'b0);
          move_to('0, 1'b1);
          for (int i = 0; i < n; i++) if (srt[i] > start) move_to(srt[i], 1'b0);
        end
      end
      ALG_CSCAN: begin
        for (int i = 0; i < n; i++) if (srt[i] >= start) move_to(srt[i], 1'b0);
        move_to(shadow_top, 1'b1);
        // the wrap to track zero counts as a full max_track move
        add_stop('0, 1'b1, shadow_top);
        for (int i = 0; i < n; i++) if (srt[i] < start) move_to(srt[i], 1'b0);
      end
      default: begin
        for (int i = 0; i < n; i++) move_to(limit_track(pending_tracks[i]), 1'b0);
      end
    endcase
    if (visits_due.size() > first_idx) visits_due[visits_due.size()-1].closes = 1'b1;
    pending_cnt = 0;
  endfunction

  // Check each result transfer, then track configuration writes and request transfers
  always @(posedge clk) begin : watch_ports
    visit_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (visits_due.size() == 0) begin
          note_failure($sformatf("unexpected result track %0d step %0d total %0d",
                                 m_tdata[15:0], m_tdata[31:16], m_tdata[55:32]));
        end else begin
          want = visits_due.pop_front();
          if (m_tdata[15:0] !== want.trk || m_tdata[31:16] !== want.step ||
              m_tdata[55:32] !== want.total || m_tuser !== want.edge_stop ||
              m_tlast !== want.closes)
            note_failure($sformatf(
              "exp trk %0d step %0d total %0d edge %0b last %0b, got %0d %0d %0d %0b %0b",
              want.trk, want.step, want.total, want.edge_stop, want.closes,
              m_tdata[15:0], m_tdata[31:16], m_tdata[55:32], m_tuser, m_tlast));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ALGORITHM: shadow_alg = cfg_data[AlgW-1:0];
          CFG_SCAN_DIR:  shadow_dir = cfg_data[0];
          CFG_START:     shadow_start = cfg_data;
          CFG_MAX_TRACK: shadow_top = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        // drop requests past the batch capacity, but still honor last
        if (pending_cnt < BatchCap) begin
          pending_tracks[pending_cnt] = limit_track(s_tdata);
          pending_cnt++;
        end
        if (s_tlast) plan_service();
      end
    end
  end

  // Result sink: random stalls, a counted hold-off on request, steady stretches
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (sink_hold > 0) begin
      m_tready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if (steady) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 32);
    end
  end

  task automatic send_request(input logic [15:0] trk, input logic lst);
    if (!steady && $urandom_range(99) < 32) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 32);
    end
    s_tvalid <= 1'b1;
    s_tdata <= trk;
    s_tlast <= lst;
    do @(posedge clk); while (!s_tready);
    sent_items++;
  endtask

  // Hold the request side until every queued result has arrived, having first waited on the clock so
  // the last request transfer has been planned
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (visits_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TrackW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [AlgW-1:0] alg, input logic dir,
                            input logic [TrackW-1:0] start, input logic [TrackW-1:0] top);
    drain();
    repeat (8) @(posedge clk);
    write_reg(CFG_ALGORITHM, TrackW'(alg));
    write_reg(CFG_SCAN_DIR, TrackW'(dir));
    write_reg(CFG_START, start);
    write_reg(CFG_MAX_TRACK, top);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_track();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, shadow_top));
  endfunction

  task automatic send_random_batch(input int n);
    for (int i = 0; i < n; i++) send_request(pick_track(), i == n - 1);
  endtask

  task automatic pick_random_config();
    logic [TrackW-1:0] top;
    logic [TrackW-1:0] start;
    case ($urandom_range(9))
      0: top = 16'hFFFF;
      1: top = 16'd1;
      2, 3: top = 16'($urandom_range(1, 65535));
      default: top = 16'($urandom_range(2, 400));
    endcase
    case ($urandom_range(9))
      0: start = '0;
      1: start = 16'hFFFF;
      2: start = 16'($urandom);
      default: start = 16'($urandom_range(0, top));
    endcase
    set_config(AlgW'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), start, top);
  endtask

  // Arrival order, with a start and tracks beyond the edge
  task automatic test_fcfs_order();
    set_config(ALG_FCFS, 1'b1, 16'd300, 16'd199);
    send_request(16'd0, 1'b0);
    send_request(16'hFFFF, 1'b0);
    send_request(16'd199, 1'b0);
    send_request(16'd37, 1'b1);
  endtask

  task automatic test_scan_toward_max();
    set_config(ALG_SCAN, 1'b1, 16'd53, 16'd199);
    send_request(16'd98, 1'b0);
    send_request(16'd14, 1'b0);
    send_request(16'd53, 1'b1);
    // nothing on the return side: the edge is still touched
    set_config(ALG_SCAN, 1'b1, 16'd0, 16'd199);
    send_request(16'd10, 1'b1);
  endtask

  task automatic test_scan_toward_zero();
    set_config(ALG_SCAN, 1'b0, 16'd53, 16'd199);
    send_request(16'd98, 1'b0);
    send_request(16'd53, 1'b0);
    send_request(16'd14, 1'b1);
  endtask

  task automatic test_cscan_wrap();
    set_config(ALG_CSCAN, 1'b1, 16'd100, 16'hFFFF);
    send_request(16'hFFFF, 1'b0);
    send_request(16'd0, 1'b0);
    send_request(16'd100, 1'b1);
  endtask

  task automatic test_spare_selector();
    set_config(ALG_SPARE, 1'b0, 16'd4, 16'd199);
    send_request(16'd5, 1'b0);
    send_request(16'd2, 1'b1);
  endtask

  // Smallest disks: everything collapses onto track zero, or onto 0 and 1
  task automatic test_tiny_disk();
    set_config(ALG_CSCAN, 1'b1, 16'd9, 16'd0);
    send_request(16'd7, 1'b1);
    set_config(ALG_SCAN, 1'b0, 16'hFFFF, 16'd1);
    send_request(16'd1, 1'b0);
    send_request(16'd0, 1'b1);
  endtask

  // Hold the sink so the block backs up, then overflow a batch with a dropped last
  task automatic test_backlog_overflow();
    set_config(ALG_CSCAN, 1'b1, 16'd1000, 16'hFFFF);
    sink_hold <= 300;
    send_random_batch(6);
    send_random_batch(BatchCap + 1);
    drain();
  endtask

  task automatic test_steady_stream();
    set_config(ALG_SCAN, 1'b1, 16'd20000, 16'hFFFF);
    steady = 1'b1;
    for (int b = 0; b < 4; b++) send_random_batch(8);
    drain();
    steady = 1'b0;
  endtask

  task automatic test_random_batches();
    int r;
    while (sent_items < 225) begin
      if ($urandom_range(2) == 0) pick_random_config();
      r = $urandom_range(99);
      if (r < 75) send_random_batch($urandom_range(1, 8));
      else if (r < 95) send_random_batch($urandom_range(9, 20));
      else send_random_batch($urandom_range(BatchCap - 4, BatchCap + 2));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fcfs_order();
    test_scan_toward_max();
    test_scan_toward_zero();
    test_cscan_wrap();
    test_spare_selector();
    test_tiny_disk();
    test_backlog_overflow();
    test_steady_stream();
    test_random_batches();
    drain();
    repeat (64) @(posedge clk);
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
